// File: hdl/face_uv_orient_and_scale_defines.svh
// ----------------------------------------------------------------------------
// face_uv_orient_and_scale_defines
// assertion macros shared by the uv orient and scale block
// ----------------------------------------------------------------------------
`ifndef FACE_UV_ORIENT_AND_SCALE_DEFINES_SVH
`define FACE_UV_ORIENT_AND_SCALE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FUOS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FUOS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fuos_pkg.sv
// ----------------------------------------------------------------------------
// fuos_pkg
// types shared by the stages of the uv orient and scale block
// ----------------------------------------------------------------------------
package fuos_pkg;

  // one request as it enters the pipeline
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [30:0]      dim_a;
    logic [30:0]      dim_b;
    logic [31:0]      u;
    logic [31:0]      v;
  } req_t;

  // request after squares and norms
  typedef struct packed {
    logic [2:0][63:0] sqa;
    logic [2:0][63:0] sqb;
    logic [63:0]      na;
    logic [63:0]      nb;
    logic [2:0]       nega;
    logic [2:0]       negb;
    logic             ok;
    logic [30:0]      dim_a;
    logic [30:0]      dim_b;
    logic [31:0]      u;
    logic [31:0]      v;
  } item_t;

  // orientation decision
  typedef struct packed {
    logic swap;
    logic fl_u;
    logic fl_v;
  } orient_t;

endpackage

// File: hdl/fuos_norm.sv
// ----------------------------------------------------------------------------
// fuos_norm
// component squares, squared norms and usability check, two stages
// ----------------------------------------------------------------------------
module fuos_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  fuos_pkg::req_t      req,
  output logic                out_vld,
  output fuos_pkg::item_t     item
);

  // len * 10^6 > 2^F  <=>  len > floor(2^F / 10^6)
  localparam logic [30:0] DIM_MIN = 31'((64'd1 << FRAC_BITS) / 64'd1000000);

  logic [2:0][31:0] mag_a, mag_b;
  logic [2:0][63:0] sq_a, sq_b;

  logic [2:0][63:0] sa, sb;
  logic [2:0]       nega, negb;
  logic             dim_ok;
  logic [30:0]      dim_a, dim_b;
  logic [31:0]      u, v;
  logic             vld_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a[i] = req.a[i][31] ? (~req.a[i] + 32'd1) : req.a[i];
      mag_b[i] = req.b[i][31] ? (~req.b[i] + 32'd1) : req.b[i];
      sq_a[i]  = 64'(mag_a[i]) * 64'(mag_a[i]);
      sq_b[i]  = 64'(mag_b[i]) * 64'(mag_b[i]);
    end
  end

  // stage a: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa     <= sq_a;
      sb     <= sq_b;
      for (int i = 0; i < 3; i++) begin
        nega[i] <= req.a[i][31];
        negb[i] <= req.b[i][31];
      end
      dim_ok <= (req.dim_a > DIM_MIN) && (req.dim_b > DIM_MIN);
      dim_a  <= req.dim_a;
      dim_b  <= req.dim_b;
      u      <= req.u;
      v      <= req.v;
    end
  end

  // stage b: norms
  logic [63:0] na_next, nb_next;

  always_comb begin
    na_next = sa[0] + sa[1] + sa[2];
    nb_next = sb[0] + sb[1] + sb[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item.sqa   <= sa;
      item.sqb   <= sb;
      item.na    <= na_next;
      item.nb    <= nb_next;
      item.nega  <= nega;
      item.negb  <= negb;
      item.ok    <= dim_ok && (na_next != 64'd0) && (nb_next != 64'd0);
      item.dim_a <= dim_a;
      item.dim_b <= dim_b;
      item.u     <= u;
      item.v     <= v;
    end
  end

endmodule

// File: hdl/fuos_orient.sv
// ----------------------------------------------------------------------------
// fuos_orient
// lean tests and axis role choice, three stages
// ----------------------------------------------------------------------------
module fuos_orient (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  fuos_pkg::item_t     item_in,
  output logic                out_vld,
  output fuos_pkg::item_t     item_out,
  output fuos_pkg::orient_t   ori
);

  localparam logic [26:0] LEAN_K = 27'd100000000;

  // stage 1: partial products
  logic [5:0][63:0]      c2;
  logic [5:0][58:0]      lp_lo_next, lp_hi_next;
  logic [3:0][63:0]      mx, my;
  logic [3:0][3:0][63:0] pp_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c2[k]     = item_in.sqa[k];
      c2[k + 3] = item_in.sqb[k];
    end
    for (int k = 0; k < 6; k++) begin
      lp_lo_next[k] = 59'(c2[k][31:0])  * 59'(LEAN_K);
      lp_hi_next[k] = 59'(c2[k][63:32]) * 59'(LEAN_K);
    end
    // z pair then y pair: a_c^2 * |b|^2 against b_c^2 * |a|^2
    mx[0] = item_in.sqa[2]; my[0] = item_in.nb;
    mx[1] = item_in.sqb[2]; my[1] = item_in.na;
    mx[2] = item_in.sqa[1]; my[2] = item_in.nb;
    mx[3] = item_in.sqb[1]; my[3] = item_in.na;
    for (int j = 0; j < 4; j++) begin
      pp_next[j][0] = 64'(mx[j][31:0])  * 64'(my[j][31:0]);
      pp_next[j][1] = 64'(mx[j][31:0])  * 64'(my[j][63:32]);
      pp_next[j][2] = 64'(mx[j][63:32]) * 64'(my[j][31:0]);
      pp_next[j][3] = 64'(mx[j][63:32]) * 64'(my[j][63:32]);
    end
  end

  logic                  vld1;
  fuos_pkg::item_t       item1;
  logic [5:0][58:0]      lp_lo, lp_hi;
  logic [3:0][3:0][63:0] pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1 <= item_in;
      lp_lo <= lp_lo_next;
      lp_hi <= lp_hi_next;
      pp    <= pp_next;
    end
  end

  // stage 2: lean flags and full products
  logic [5:0]        lean_next;
  logic [3:0][127:0] prod_next;
  logic [91:0]       lval;
  logic [91:0]       nval;

  always_comb begin
    lean_next = '0;
    lval      = '0;
    nval      = '0;
    for (int k = 0; k < 6; k++) begin
      lval = {1'b0, lp_hi[k], 32'd0} + 92'(lp_lo[k]);
      nval = 92'(k < 3 ? item1.na : item1.nb);
      lean_next[k] = lval > nval;
    end
    for (int j = 0; j < 4; j++) begin
      prod_next[j] = {pp[j][3], 64'd0} + {32'd0, pp[j][1], 32'd0}
                   + {32'd0, pp[j][2], 32'd0} + {64'd0, pp[j][0]};
    end
  end

  logic              vld2;
  fuos_pkg::item_t   item2;
  logic [5:0]        lean;
  logic [3:0][127:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item2 <= item1;
      lean  <= lean_next;
      prod  <= prod_next;
    end
  end

  // stage 3: role choice and mirror signs
  fuos_pkg::orient_t ori_next;
  logic more_z, more_y;

  always_comb begin
    more_z   = prod[0] > prod[1];
    more_y   = prod[2] > prod[3];
    ori_next = '0;
    if (lean[2] || lean[5]) begin
      ori_next.swap = more_z;
      ori_next.fl_v = more_z ? item2.nega[2] : item2.negb[2];
    end else begin
      ori_next.swap = more_y;
      if (more_y ? lean[1] : lean[4]) begin
        ori_next.fl_v = more_y ? item2.nega[1] : item2.negb[1];
      end else if (more_y ? lean[0] : lean[3]) begin
        ori_next.fl_v = more_y ? item2.nega[0] : item2.negb[0];
      end
    end
    // u is the other axis
    if (ori_next.swap ? lean[3] : lean[0]) begin
      ori_next.fl_u = ori_next.swap ? item2.negb[0] : item2.nega[0];
    end else if (ori_next.swap ? lean[4] : lean[1]) begin
      ori_next.fl_u = ori_next.swap ? item2.negb[1] : item2.nega[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out <= item2;
      ori      <= ori_next;
    end
  end

endmodule

// File: hdl/fuos_scale.sv
// ----------------------------------------------------------------------------
// fuos_scale
// swap, mirror and scale of the uv point about one half, three stages
// ----------------------------------------------------------------------------
module fuos_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  fuos_pkg::item_t     item,
  input  fuos_pkg::orient_t   ori,
  output logic                out_vld,
  output logic signed [31:0]  ground_u,
  output logic signed [31:0]  ground_v,
  output logic                valid_res,
  output logic                swapped,
  output logic                u_flipped,
  output logic                v_flipped,
  output logic [30:0]         face_width,
  output logic [30:0]         face_height,
  output logic                clipped
);

  localparam logic signed [33:0] HALF    = 34'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] HALF_W  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  // stage 1: offset from one half, mirror folded in
  logic signed [33:0] xu, xv, du_next, dv_next;

  always_comb begin
    xu      = ori.swap ? {{2{item.v[31]}}, item.v} : {{2{item.u[31]}}, item.u};
    xv      = ori.swap ? {{2{item.u[31]}}, item.u} : {{2{item.v[31]}}, item.v};
    du_next = ori.fl_u ? (HALF - xu) : (xu - HALF);
    dv_next = ori.fl_v ? (HALF - xv) : (xv - HALF);
  end

  logic               vld1;
  logic signed [33:0] du, dv;
  logic [30:0]        w1, h1;
  fuos_pkg::orient_t  ori1;
  logic               ok1;
  logic [31:0]        u1, v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du   <= du_next;
      dv   <= dv_next;
      w1   <= ori.swap ? item.dim_b : item.dim_a;
      h1   <= ori.swap ? item.dim_a : item.dim_b;
      ori1 <= ori;
      ok1  <= item.ok;
      u1   <= item.u;
      v1   <= item.v;
    end
  end

  // stage 2: split products, low 17 bits unsigned and high part signed
  logic               vld2;
  logic [47:0]        pl_u, pl_v;
  logic signed [48:0] ph_u, ph_v;
  logic [30:0]        w2, h2;
  fuos_pkg::orient_t  ori2;
  logic               ok2;
  logic [31:0]        u2, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_u <= 48'(du[16:0]) * 48'(w1);
      pl_v <= 48'(dv[16:0]) * 48'(h1);
      ph_u <= $signed(du[33:17]) * $signed({1'b0, w1});
      ph_v <= $signed(dv[33:17]) * $signed({1'b0, h1});
      w2   <= w1;
      h2   <= h1;
      ori2 <= ori1;
      ok2  <= ok1;
      u2   <= u1;
      v2   <= v1;
    end
  end

  // stage 3: round, shift back, saturate
  logic signed [65:0] pu, pv, gu, gv;
  logic               hi_u, lo_u, hi_v, lo_v;
  logic signed [31:0] su, sv;

  always_comb begin
    pu   = {{17{ph_u[48]}}, ph_u} * 66'sd131072 + $signed({18'd0, pl_u}) + HALF_W;
    pv   = {{17{ph_v[48]}}, ph_v} * 66'sd131072 + $signed({18'd0, pl_v}) + HALF_W;
    gu   = (pu >>> FRAC_BITS) + HALF_W;
    gv   = (pv >>> FRAC_BITS) + HALF_W;
    hi_u = gu > SAT_MAX;
    lo_u = gu < SAT_MIN;
    hi_v = gv > SAT_MAX;
    lo_v = gv < SAT_MIN;
    su   = hi_u ? 32'sh7fffffff : (lo_u ? 32'sh80000000 : gu[31:0]);
    sv   = hi_v ? 32'sh7fffffff : (lo_v ? 32'sh80000000 : gv[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ground_u    <= ok2 ? su : u2;
      ground_v    <= ok2 ? sv : v2;
      valid_res   <= ok2;
      swapped     <= ok2 && ori2.swap;
      u_flipped   <= ok2 && ori2.fl_u;
      v_flipped   <= ok2 && ori2.fl_v;
      face_width  <= ok2 ? w2 : 31'd0;
      face_height <= ok2 ? h2 : 31'd0;
      clipped     <= ok2 && (hi_u || lo_u || hi_v || lo_v);
    end
  end

endmodule

// File: hdl/face_uv_orient_and_scale.sv
// throughput: one request per cycle while the output is empty or drained, set by the eight-stage pipeline moving as one
// a stall of the output holds every stage; in_ready follows out_ready while full
// reset (synchronous, active high) clears all stage valid bits; no other state
// ----------------------------------------------------------------------------
// face_uv_orient_and_scale
// orients a face uv point to world axes and scales it by the edge lengths
// ----------------------------------------------------------------------------
`include "face_uv_orient_and_scale_defines.svh"

module face_uv_orient_and_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] axis_a_x,
  input  logic signed [31:0] axis_a_y,
  input  logic signed [31:0] axis_a_z,
  input  logic signed [31:0] axis_b_x,
  input  logic signed [31:0] axis_b_y,
  input  logic signed [31:0] axis_b_z,
  input  logic [30:0]        dim_a,
  input  logic [30:0]        dim_b,
  input  logic signed [31:0] face_u,
  input  logic signed [31:0] face_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] ground_u,
  output logic signed [31:0] ground_v,
  output logic               valid_res,
  output logic               swapped,
  output logic               u_flipped,
  output logic               v_flipped,
  output logic [30:0]        face_width,
  output logic [30:0]        face_height,
  output logic               clipped
);

  // the whole pipe advances whenever the output register is free or drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // pack the request
  fuos_pkg::req_t req;

  always_comb begin
    req.a[0]  = axis_a_x;
    req.a[1]  = axis_a_y;
    req.a[2]  = axis_a_z;
    req.b[0]  = axis_b_x;
    req.b[1]  = axis_b_y;
    req.b[2]  = axis_b_z;
    req.dim_a = dim_a;
    req.dim_b = dim_b;
    req.u     = face_u;
    req.v     = face_v;
  end

  // squares and norms
  logic            norm_vld;
  fuos_pkg::item_t norm_item;

  fuos_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .req     (req),
    .out_vld (norm_vld),
    .item    (norm_item)
  );

  // lean tests and role choice
  logic              ori_vld;
  fuos_pkg::item_t   ori_item;
  fuos_pkg::orient_t ori;

  fuos_orient u_orient (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (norm_vld),
    .item_in  (norm_item),
    .out_vld  (ori_vld),
    .item_out (ori_item),
    .ori      (ori)
  );

  // mirror, scale, saturate; last stage is the output register
  fuos_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_vld      (ori_vld),
    .item        (ori_item),
    .ori         (ori),
    .out_vld     (out_valid),
    .ground_u    (ground_u),
    .ground_v    (ground_v),
    .valid_res   (valid_res),
    .swapped     (swapped),
    .u_flipped   (u_flipped),
    .v_flipped   (v_flipped),
    .face_width  (face_width),
    .face_height (face_height),
    .clipped     (clipped)
  );

  // an unusable request carries no orientation or size
  `FUOS_ASSERT_IMPL(a_invalid_clear, clk, rst, out_valid && !valid_res, !swapped && !u_flipped && !v_flipped && !clipped && face_width == 31'd0 && face_height == 31'd0, "invalid request with flags set")

  // clipping only ever reports a coordinate pinned at a rail
  `FUOS_ASSERT_IMPL(a_clip_rail, clk, rst, out_valid && clipped, ground_u == 32'sh7fffffff || ground_u == 32'sh80000000 || ground_v == 32'sh7fffffff || ground_v == 32'sh80000000, "clip flag without saturated coordinate")

  // after a drain, the input side is ready unless a new result waits at the output
  `FUOS_ASSERT_NEXT(a_drain_ready, clk, rst, out_valid && out_ready, in_ready || out_valid, "input blocked after drain")

endmodule

// File: tb/tb_face_uv_orient_and_scale.sv
// ----------------------------------------------------------------------------
// tb_face_uv_orient_and_scale
// checks uv orientation and scaling against a behavioural predictor, with
// random sender bursts, receiver stalls and a long output hold-off
// ----------------------------------------------------------------------------
module tb_face_uv_orient_and_scale;

  localparam int FRAC = 16;
  localparam int LAT  = 8;

  // expected result of one request
  typedef struct {
    logic signed [31:0] gu;
    logic signed [31:0] gv;
    logic               ok;
    logic               swp;
    logic               flu;
    logic               flv;
    logic [30:0]        w;
    logic [30:0]        h;
    logic               clip;
  } uv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] axis_a_x = '0, axis_a_y = '0, axis_a_z = '0;
  logic signed [31:0] axis_b_x = '0, axis_b_y = '0, axis_b_z = '0;
  logic [30:0] dim_a = '0, dim_b = '0;
  logic signed [31:0] face_u = '0, face_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] ground_u, ground_v;
  logic valid_res, swapped, u_flipped, v_flipped, clipped;
  logic [30:0] face_width, face_height;

  uv_result_t pending_uv[$];
  int  fail_count = 0;
  bit  hold_off = 1'b0;
  event hold_go;

  face_uv_orient_and_scale #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [127:0] sq64(input logic signed [31:0] c);
    logic [63:0] m;
    m = (c < 0) ? 64'(-64'(c)) : 64'(c);
    return 128'(m) * 128'(m);
  endfunction

  // |c|/|v| > 1e-4, exact
  function automatic bit tilts(input logic [127:0] c2, input logic [127:0] n2);
    return (c2 * 128'd100000000) > n2;
  endfunction

  function automatic bit tilts_more(input logic [127:0] ca2, na2, cb2, nb2);
    logic [255:0] l, r;
    l = 256'(ca2) * 256'(nb2);
    r = 256'(cb2) * 256'(na2);
    return l > r;
  endfunction

  function automatic logic signed [31:0] scale_about_half(
      input logic signed [63:0] x, input bit mirror, input logic [30:0] len,
      inout logic clip);
    logic signed [127:0] xx, p, g;
    xx = x;
    if (mirror) xx = (128'sd1 <<< FRAC) - xx;
    p = (xx - (128'sd1 <<< (FRAC - 1))) * $signed({97'd0, len})
        + (128'sd1 <<< (FRAC - 1));
    g = (p >>> FRAC) + (128'sd1 <<< (FRAC - 1)); // arithmetic shift is floor
    if (g > 128'sd2147483647) begin
      g = 128'sd2147483647; clip = 1'b1;
    end
    if (g < -128'sd2147483648) begin
      g = -128'sd2147483648; clip = 1'b1;
    end
    return g[31:0];
  endfunction

  function automatic uv_result_t orient_uv(
      input logic signed [31:0] ax, ay, az, bx, by, bz,
      input logic [30:0] da, db, input logic signed [31:0] fu, fv);
    uv_result_t r;
    logic [127:0] na, nb, nu, nv;
    logic signed [31:0] ua[3], va[3];
    logic [63:0] lim;
    bit swp, flu, flv;
    lim = 64'd1 << FRAC;
    na = sq64(ax) + sq64(ay) + sq64(az);
    nb = sq64(bx) + sq64(by) + sq64(bz);
    r = '{fu, fv, 0, 0, 0, 0, '0, '0, 0};
    if (64'(da) * 64'd1000000 <= lim || 64'(db) * 64'd1000000 <= lim
        || na == 0 || nb == 0) return r;
    flu = 0; flv = 0;
    if (tilts(sq64(az), na) || tilts(sq64(bz), nb)) begin
      swp = tilts_more(sq64(az), na, sq64(bz), nb);
      flv = swp ? (az < 0) : (bz < 0);
    end else begin
      swp = tilts_more(sq64(ay), na, sq64(by), nb);
      if (swp) begin
        va[0] = ax; va[1] = ay; va[2] = az;
      end else begin
        va[0] = bx; va[1] = by; va[2] = bz;
      end
      nv = swp ? na : nb;
      if (tilts(sq64(va[1]), nv)) flv = va[1] < 0;
      else if (tilts(sq64(va[0]), nv)) flv = va[0] < 0;
    end
    if (swp) begin
      ua[0] = bx; ua[1] = by; ua[2] = bz;
    end else begin
      ua[0] = ax; ua[1] = ay; ua[2] = az;
    end
    nu = swp ? nb : na;
    if (tilts(sq64(ua[0]), nu)) flu = ua[0] < 0;
    else if (tilts(sq64(ua[1]), nu)) flu = ua[1] < 0;
    r.ok = 1; r.swp = swp; r.flu = flu; r.flv = flv;
    r.w = swp ? db : da;
    r.h = swp ? da : db;
    r.gu = scale_about_half(swp ? fv : fu, flu, r.w, r.clip);
    r.gv = scale_about_half(swp ? fu : fv, flv, r.h, r.clip);
    return r;
  endfunction

  // ---------------------------------------------------------------- sending

  bit burst_mode = 1'b1;

  // one request; a random gap may precede it when bursting is on
  task automatic send_face(input logic signed [31:0] ax, ay, az, bx, by, bz,
                           input logic [30:0] da, db,
                           input logic signed [31:0] fu, fv);
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    axis_a_x <= ax; axis_a_y <= ay; axis_a_z <= az;
    axis_b_x <= bx; axis_b_y <= by; axis_b_z <= bz;
    dim_a <= da; dim_b <= db; face_u <= fu; face_v <= fv;
    pending_uv.push_back(orient_uv(ax, ay, az, bx, by, bz, da, db, fu, fv));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 32'sd0;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rnd_len();
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(0, 2));
      1: return 31'($urandom_range(0, 1 << 20));
      2: return 31'h7fffffff;
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_uv();
    return $urandom_range(0, 2) == 0 ? $urandom()
         : $signed($urandom_range(0, 196608)) - 65536;
  endfunction

  task automatic send_random(input int n);
    repeat (n)
      send_face(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
                rnd_comp(), rnd_len(), rnd_len(), rnd_uv(), rnd_uv());
  endtask

  // ---------------------------------------------------------------- tests

  localparam logic signed [31:0] ONE = 32'sh10000;
  localparam logic signed [31:0] MAXS = 32'sh7fffffff, MINS = 32'sh80000000;
  localparam logic [30:0] LMAX = 31'h7fffffff;
  localparam logic [30:0] LONE = 31'h10000;

  task automatic test_invalid_items();
    // length at the threshold on either side, both lengths one, zero axes
    send_face(ONE, 0, 0, 0, ONE, 0, 31'd0, 31'd65536, 32'sd1234, -32'sd5);
    send_face(ONE, 0, 0, 0, ONE, 0, 31'd65537, 31'd0, MAXS, MINS);
    send_face(ONE, 0, 0, 0, ONE, 0, 31'd1, 31'd1, ONE, ONE);
    send_face(0, 0, 0, 0, ONE, 0, LONE, LONE, 32'sd7, 32'sd9);
    send_face(ONE, 0, 0, 0, 0, 0, LONE, LONE, MINS, MAXS);
  endtask

  task automatic test_orientation();
    // z-leaning axes, either one, negative z, tie
    send_face(0, 0, ONE, ONE, 0, 0, 31'd131072, 31'd65536, 32'sd16384, 32'sd49152);
    send_face(ONE, 0, 0, 0, 0, -ONE, 31'd65536, 31'd196608, 32'sd100, 32'sd200);
    send_face(0, ONE, ONE, ONE, 0, ONE, LONE, LONE, 32'sd30000, 32'sd40000);
    // y-leaning, negative y, tie goes to b
    send_face(0, -ONE, 0, -ONE, 0, 0, LONE, 31'd32768, 32'sd1, 32'sd2);
    send_face(ONE, ONE, 0, ONE, ONE, 0, LONE, LONE, 32'sd5000, -32'sd5000);
    // v falls back to x sign, u falls back to y sign
    send_face(-ONE, 0, 0, -ONE, 0, 0, LONE, LONE, 32'sd9, 32'sd99);
    send_face(0, -ONE, 0, 0, -ONE, 0, LONE, LONE, 32'sd9, 32'sd99);
    // leaning just above and below 1e-4
    send_face(MAXS, 0, 32'sd214749, MAXS, 32'sd214747, 0, LONE, LONE, 0, ONE);
    send_face(-32'sd1, 32'sd1, MINS, MAXS, MINS, 32'sd1, LMAX, 31'd1, ONE, 0);
  endtask

  task automatic test_saturation();
    send_face(ONE, 0, 0, 0, ONE, 0, LMAX, LMAX, MAXS, MINS);
    send_face(-ONE, 0, 0, 0, -ONE, 0, LMAX, LMAX, MINS, MAXS);
    send_face(MINS, MINS, MINS, MAXS, MAXS, MAXS, LMAX, LMAX, MAXS, MAXS);
    send_face(32'sd1, 0, 0, 0, 0, 32'sd1, 31'd1 << 30, 31'd3, MINS, -ONE);
  endtask

  task automatic test_random_traffic();
    send_random(380);
  endtask

  // receiver holds off long so the pipeline fills and stalls the sender
  task automatic test_backpressure();
    -> hold_go;
    burst_mode = 1'b0;
    send_random(40);
    burst_mode = 1'b1;
  endtask

  // sender waits for the pipeline to drain
  task automatic drain();
    go_idle();
    while (pending_uv.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern, with a forced long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_ready <= ($urandom_range(0, 2) == 0);
      default: out_ready <= 1'b1;
    endcase
  end

  // long hold-off, counted in cycles
  always begin
    @(hold_go);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    uv_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_uv.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = pending_uv.pop_front();
        if (ground_u !== e.gu) begin
          $error("ground_u exp %0d got %0d", e.gu, ground_u); fail_count++;
        end
        if (ground_v !== e.gv) begin
          $error("ground_v exp %0d got %0d", e.gv, ground_v); fail_count++;
        end
        if (valid_res !== e.ok) begin
          $error("valid_res exp %0b got %0b", e.ok, valid_res); fail_count++;
        end
        if (swapped !== e.swp) begin
          $error("swapped exp %0b got %0b", e.swp, swapped); fail_count++;
        end
        if (u_flipped !== e.flu) begin
          $error("u_flipped exp %0b got %0b", e.flu, u_flipped); fail_count++;
        end
        if (v_flipped !== e.flv) begin
          $error("v_flipped exp %0b got %0b", e.flv, v_flipped); fail_count++;
        end
        if (face_width !== e.w) begin
          $error("face_width exp %0d got %0d", e.w, face_width); fail_count++;
        end
        if (face_height !== e.h) begin
          $error("face_height exp %0d got %0d", e.h, face_height); fail_count++;
        end
        if (clipped !== e.clip) begin
          $error("clipped exp %0b got %0b", e.clip, clipped); fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invalid_items();
    test_orientation();
    test_saturation();
    drain();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (LAT * 4) @(posedge clk);
    if (fail_count == 0 && pending_uv.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
